// ----- rtl/pwcn_pkg.sv -----
// Package for the weighted-centroid nearest-sensor block.
// Holds sizes, payload types, state codes and saturation helpers; no dependencies.
`timescale 1ns / 1ps
package pwcn_pkg;
	localparam int NUM_SENSORS = 1024;
	localparam int CHANNELS_PER_SENSOR = 16;
	localparam int SENSOR_W = $clog2(NUM_SENSORS);
	localparam int WSUM_W = 32;
	localparam int MOM_W = 48;
	localparam int CROSSED_BIT = 30;
	localparam logic [47:0] DIST_LIMIT = 48'd65536000000;
	localparam logic signed [MOM_W-1:0] MOM_MAX = {1'b0, {(MOM_W-1){1'b1}}};
	localparam logic signed [MOM_W-1:0] MOM_MIN = {1'b1, {(MOM_W-1){1'b0}}};
	localparam int ENTRY_W = WSUM_W + 2 * MOM_W;

	typedef struct packed {
		logic mode;
		logic [13:0] channel;
		logic [31:0] status_word;
		logic [15:0] weight;
		logic signed [15:0] hit_x;
		logic signed [15:0] hit_y;
		logic signed [15:0] track_x;
		logic signed [15:0] track_y;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [9:0] winner_sensor;
		logic signed [15:0] centroid_x;
		logic signed [15:0] centroid_y;
	} out_item_t;

	typedef struct packed {
		logic [WSUM_W-1:0] wsum;
		logic signed [MOM_W-1:0] xmom;
		logic signed [MOM_W-1:0] ymom;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_DIV, ST_DIST, ST_NEXT, ST_OUT
	} state_t;

	function automatic logic signed [MOM_W-1:0] sat_add(
		input logic signed [MOM_W-1:0] a, input logic signed [32:0] b);
		logic signed [MOM_W:0] s;
		begin
			s = {a[MOM_W-1], a} + {{(MOM_W-32){b[32]}}, b};
			if (s > $signed({1'b0, MOM_MAX})) sat_add = MOM_MAX;
			else if (s < $signed({1'b1, MOM_MIN})) sat_add = MOM_MIN;
			else sat_add = s[MOM_W-1:0];
		end
	endfunction
endpackage

// ----- rtl/pwcn_if.sv -----
// Valid/ready channel interface carrying one payload type.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps
interface pwcn_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pwcn_div.sv -----
// Restoring divider: rounded Q8 centroid from a Q16 moment and Q8 weight.
// One quotient bit per cycle; uses pwcn_pkg.
`timescale 1ns / 1ps
module pwcn_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [pwcn_pkg::MOM_W-1:0] moment,
	input logic [pwcn_pkg::WSUM_W-1:0] wsum,
	output logic done,
	output logic signed [15:0] result
);
	import pwcn_pkg::*;
	localparam int NUM_W = MOM_W + 2;
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] num_q;
	logic [WSUM_W+1:0] den_q;
	logic [WSUM_W+2:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, neg_q;
	logic [WSUM_W+2:0] trial;
	logic [MOM_W:0] mag;

	always_comb begin
		mag = moment[MOM_W-1] ? -{moment[MOM_W-1], moment} : {1'b0, moment};
		trial = {rem_q[WSUM_W+1:0], num_q[NUM_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= moment[MOM_W-1];
			num_q <= {mag, 1'b0} + NUM_W'(wsum);
			den_q <= {1'b0, wsum, 1'b0};
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) result = (num_q > NUM_W'(32768)) ? 16'sh8000 : 16'(-num_q);
		else result = (num_q > NUM_W'(32767)) ? 16'sh7fff : 16'(num_q);
	end
endmodule

// ----- rtl/pwcn_core.sv -----
// Sum memory, hit accumulation with forwarding, and sensor scan sequencer.
// Uses pwcn_pkg and pwcn_div.
`timescale 1ns / 1ps
module pwcn_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pwcn_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pwcn_pkg::out_item_t out_data
);
	import pwcn_pkg::*;
	entry_t mem [NUM_SENSORS];
	entry_t rd_q;
	state_t state_q, state_d;
	logic [SENSOR_W:0] idx_q;
	logic hit_s1;
	logic [SENSOR_W-1:0] addr_s1;
	logic [15:0] w_s1;
	logic signed [31:0] px_s1, py_s1;
	logic wr_en;
	logic [SENSOR_W-1:0] wr_addr, rd_addr;
	entry_t wr_data, cur;
	logic fwd_q;
	entry_t fwd_data_q;
	logic signed [15:0] tx_q, ty_q, cx_q;
	logic [47:0] best_q;
	logic found_q;
	logic [SENSOR_W-1:0] win_q;
	logic signed [15:0] wx_q, wy_q;
	logic div_start, div_done;
	logic div_sel_q;
	logic signed [15:0] div_res;
	logic signed [16:0] dx, dy;
	logic [33:0] dx2_q, dy2_q;
	logic [47:0] dist_sum;
	logic [SENSOR_W-1:0] sensor;
	logic accept, hit_ok;
	logic [32:0] ws;

	assign accept = in_valid && in_ready;
	assign sensor = SENSOR_W'(in_data.channel / CHANNELS_PER_SENSOR);
	assign hit_ok = accept && !in_data.mode && in_data.status_word[CROSSED_BIT]
		&& (32'(in_data.channel / CHANNELS_PER_SENSOR) < NUM_SENSORS);
	assign in_ready = (state_q == ST_IDLE) && !(in_data.mode && hit_s1);

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = (accept && in_data.mode) ? '0 : sensor;
		end else if (state_q == ST_NEXT) begin
			rd_addr = idx_q[SENSOR_W-1:0] + 1'b1;
		end else begin
			rd_addr = idx_q[SENSOR_W-1:0];
		end
		cur = fwd_q ? fwd_data_q : rd_q;
		ws = {1'b0, cur.wsum} + 33'(w_s1);
		wr_en = 1'b0;
		wr_addr = addr_s1;
		wr_data.wsum = ws[32] ? '1 : ws[31:0];
		wr_data.xmom = sat_add(cur.xmom, {px_s1[31], px_s1});
		wr_data.ymom = sat_add(cur.ymom, {py_s1[31], py_s1});
		if (hit_s1) wr_en = 1'b1;
		if (state_q == ST_CLEAR || state_q == ST_NEXT) begin
			wr_en = 1'b1;
			wr_addr = idx_q[SENSOR_W-1:0];
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
		fwd_q <= hit_s1 && hit_ok && (addr_s1 == sensor);
		fwd_data_q <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (hit_ok) begin
			addr_s1 <= sensor;
			w_s1 <= in_data.weight;
			px_s1 <= $signed({1'b0, in_data.weight}) * in_data.hit_x;
			py_s1 <= $signed({1'b0, in_data.weight}) * in_data.hit_y;
		end
		if (accept && in_data.mode) begin
			tx_q <= in_data.track_x;
			ty_q <= in_data.track_y;
		end
	end

	assign dx = {cx_q[15], cx_q} - {tx_q[15], tx_q};
	assign dy = {div_res[15], div_res} - {ty_q[15], ty_q};
	assign dist_sum = 48'(dx2_q) + 48'(dy2_q);
	assign div_start = (state_q == ST_SCAN_RD && idx_q[SENSOR_W] == 1'b0 && rd_q.wsum != '0)
		|| (state_q == ST_DIV && div_done && !div_sel_q);

	pwcn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.moment((state_q == ST_DIV) ? rd_q.ymom : rd_q.xmom),
		.wsum(rd_q.wsum), .done(div_done), .result(div_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (idx_q == (SENSOR_W+1)'(NUM_SENSORS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (accept && in_data.mode) state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = div_start ? ST_DIV : ST_NEXT;
			ST_DIV: if (div_done && div_sel_q) state_d = ST_DIST;
			ST_DIST: state_d = ST_NEXT;
			ST_NEXT: state_d = (idx_q == (SENSOR_W+1)'(NUM_SENSORS - 1)) ? ST_OUT : ST_SCAN_RD;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			hit_s1 <= 1'b0;
			div_sel_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_s1 <= hit_ok;
			case (state_q)
				ST_CLEAR: idx_q <= (state_d == ST_IDLE) ? '0 : idx_q + 1'b1;
				ST_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					best_q <= DIST_LIMIT;
				end
				ST_SCAN_RD: div_sel_q <= 1'b0;
				ST_DIV: if (div_done) begin
					if (!div_sel_q) begin
						cx_q <= div_res;
						div_sel_q <= 1'b1;
					end else begin
						dx2_q <= 34'($signed(dx) * $signed(dx));
						dy2_q <= 34'($signed(dy) * $signed(dy));
					end
				end
				ST_DIST: if (dist_sum < best_q) begin
					best_q <= dist_sum;
					found_q <= 1'b1;
					win_q <= idx_q[SENSOR_W-1:0];
					wx_q <= cx_q;
				end
				ST_NEXT: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	logic signed [15:0] wyo_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done && div_sel_q) wyo_q <= div_res;
		if (state_q == ST_DIST && dist_sum < best_q) wy_q <= wyo_q;
	end

	assign out_valid = (state_q == ST_OUT);
	assign out_data.found = found_q;
	assign out_data.winner_sensor = found_q ? 10'(win_q) : '0;
	assign out_data.centroid_x = found_q ? wx_q : '0;
	assign out_data.centroid_y = found_q ? wy_q : '0;
endmodule

// ----- rtl/pmt_weighted_centroid_nearest.sv -----
// Top level of the weighted-centroid nearest-sensor block.
// Uses pwcn_pkg, pwcn_if and pwcn_core.
//
// channel  role    payload
// in_ch    sink    mode, channel, status_word, weight, hit_x, hit_y, track_x, track_y
// out_ch   source  found, winner_sensor, centroid_x, centroid_y
//
// Hit transactions are taken one per cycle; the sum memory is read, updated and
// written back with forwarding between back-to-back hits on one sensor.
// A finish transaction is held off while a hit is still being written back.
// A finish transaction scans all 1024 sensors: an empty sensor passes through the read
// and next states only, a filled one runs the bit-serial divider twice, once per axis.
// After reset the sum memory is cleared entry by entry while no transaction is taken.
`timescale 1ns / 1ps
module pmt_weighted_centroid_nearest (
	input logic clk,
	input logic arst_n,
	pwcn_if.sink in_ch,
	pwcn_if.source out_ch
);
	import pwcn_pkg::*;
	pwcn_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

// ----- rtl/pwcn_checker.sv -----
// Port-level checks for the weighted-centroid nearest-sensor block.
// Depends on no package; bound to pmt_weighted_centroid_nearest.
`timescale 1ns / 1ps
module pwcn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_mode,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic [9:0] out_winner
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_winner == 10'd0) else $error("winner not zero");
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode |=> !in_ready) else $error("scan not started");
endmodule

bind pmt_weighted_centroid_nearest pwcn_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.data.mode),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_found(out_ch.data.found), .out_winner(out_ch.data.winner_sensor)
);

// ----- sim/pmt_weighted_centroid_nearest_tb.sv -----
// Testbench for pmt_weighted_centroid_nearest: directed table then random events, results
// checked against table entries or a built-in sensor-sum predictor. Depends on pwcn_pkg, pwcn_if.
`timescale 1ns / 1ps
module pmt_weighted_centroid_nearest_tb;
	import pwcn_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam bit MODE_HIT = 1'b0;
	localparam bit MODE_FINISH = 1'b1;
	localparam logic [31:0] CROSSED = 32'h4000_0000;

	typedef struct {
		in_item_t item;
		bit typed;
		out_item_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	pwcn_if #(.T(in_item_t)) in_ch ();
	pwcn_if #(.T(out_item_t)) out_ch ();

	pmt_weighted_centroid_nearest DUT (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	logic [31:0] wsum_model [NUM_SENSORS];
	longint xmom_model [NUM_SENSORS];
	longint ymom_model [NUM_SENSORS];
	out_item_t pending_results [$];
	stim_row_t directed_rows [$];
	bit idling_on = 1'b1;
	bit failed = 1'b0;
	int unsigned cycles = 0;
	int sent_items = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint sat_moment(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< 47) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint q8_mean(longint m, logic [31:0] w);
		longint unsigned mag, wl, q;
		wl = w;
		mag = (m < 0) ? longint'(-m) : m;
		q = (2 * mag + wl) / (2 * wl);
		if (m < 0) return (q > 32768) ? -32768 : -longint'(q);
		return (q > 32767) ? 32767 : longint'(q);
	endfunction

	function automatic void clear_sums();
		for (int i = 0; i < NUM_SENSORS; i++) begin
			wsum_model[i] = '0;
			xmom_model[i] = 0;
			ymom_model[i] = 0;
		end
	endfunction

	// Updates the sensor sums on a hit; on a finish returns 1 with the nearest-sensor result and clears the sums.
	function automatic bit predict_nearest(in_item_t it, output out_item_t res);
		int s;
		longint unsigned ws;
		longint best, cx, cy, dx, dy, d;
		res = '0;
		if (it.mode == MODE_HIT) begin
			s = it.channel / CHANNELS_PER_SENSOR;
			if (!it.status_word[CROSSED_BIT] || s >= NUM_SENSORS) return 0;
			ws = longint'(wsum_model[s]) + longint'(it.weight);
			wsum_model[s] = (ws > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ws[31:0];
			xmom_model[s] = sat_moment(xmom_model[s] + longint'(it.weight) * longint'(it.hit_x));
			ymom_model[s] = sat_moment(ymom_model[s] + longint'(it.weight) * longint'(it.hit_y));
			return 0;
		end
		best = longint'(DIST_LIMIT);
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (wsum_model[i] != 0) begin
				cx = q8_mean(xmom_model[i], wsum_model[i]);
				cy = q8_mean(ymom_model[i], wsum_model[i]);
				dx = cx - longint'(it.track_x);
				dy = cy - longint'(it.track_y);
				d = dx * dx + dy * dy;
				if (d < best) begin
					best = d;
					res.found = 1'b1;
					res.winner_sensor = i[9:0];
					res.centroid_x = cx[15:0];
					res.centroid_y = cy[15:0];
				end
			end
		end
		clear_sums();
		return 1;
	endfunction

	function automatic in_item_t hit_item(int ch, logic [31:0] st, logic [15:0] w,
		logic [15:0] x, logic [15:0] y);
		in_item_t it;
		it = '0;
		it.mode = MODE_HIT;
		it.channel = ch[13:0];
		it.status_word = st;
		it.weight = w;
		it.hit_x = x;
		it.hit_y = y;
		it.track_x = 16'($urandom);
		it.track_y = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t finish_item(logic [15:0] tx, logic [15:0] ty);
		in_item_t it;
		it = '0;
		it.mode = MODE_FINISH;
		it.channel = 14'($urandom);
		it.status_word = $urandom;
		it.weight = 16'($urandom);
		it.hit_x = 16'($urandom);
		it.hit_y = 16'($urandom);
		it.track_x = tx;
		it.track_y = ty;
		return it;
	endfunction

	function automatic void add_row(in_item_t it, bit typed = 0, out_item_t res = '0);
		stim_row_t r;
		r.item = it;
		r.typed = typed;
		r.result = res;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	task automatic send_item(in_item_t it, bit typed = 0, out_item_t res = '0);
		bit acc;
		out_item_t predicted;
		while (idling_on && $urandom_range(99) < 11) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.data <= it;
		in_ch.valid <= 1'b1;
		do begin
			@(negedge clk);
			acc = in_ch.ready;
			@(posedge clk);
		end while (!acc);
		if (predict_nearest(it, predicted))
			pending_results.insert(pending_results.size(), typed ? res : predicted);
		sent_items++;
	endtask

	always @(posedge clk)
		out_ch.ready <= !idling_on || ($urandom_range(99) >= 11);

	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, out_ch.data.found);
					failed = 1'b1;
				end
				if (out_ch.data.winner_sensor !== want.winner_sensor) begin
					$error("winner_sensor: expected %0d, got %0d", want.winner_sensor,
						out_ch.data.winner_sensor);
					failed = 1'b1;
				end
				if (out_ch.data.centroid_x !== want.centroid_x) begin
					$error("centroid_x: expected %0d, got %0d", want.centroid_x,
						out_ch.data.centroid_x);
					failed = 1'b1;
				end
				if (out_ch.data.centroid_y !== want.centroid_y) begin
					$error("centroid_y: expected %0d, got %0d", want.centroid_y,
						out_ch.data.centroid_y);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		out_item_t none, r;
		int shared_sensors [4];
		int nhits, sensor;
		logic [31:0] st;

		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		clear_sums();
		none = '0;

		// Nothing filled after reset: no sensor found.
		add_row(finish_item(16'h0000, 16'h0000), 1, none);
		// Bit 30 clear is ignored even with every other status bit set.
		add_row(hit_item(0, 32'hBFFF_FFFF, 16'hFFFF, 16'h0100, 16'h0100));
		add_row(finish_item(16'h7FFF, 16'h8000), 1, none);
		// Single hit gives an exact centroid.
		add_row(hit_item(3, CROSSED, 16'h0100, 16'h0100, 16'h0000));
		r = '{found: 1'b1, winner_sensor: 10'd0, centroid_x: 16'sh0100, centroid_y: 16'sh0000};
		add_row(finish_item(16'h0000, 16'h0000), 1, r);
		// Extreme coordinates and weight on the top channel.
		add_row(hit_item(16383, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h7FFF));
		r = '{found: 1'b1, winner_sensor: 10'd1023, centroid_x: 16'sh8000,
			centroid_y: 16'sh7FFF};
		add_row(finish_item(16'h7FFF, 16'h8000), 1, r);
		// Zero weight leaves the sensor empty.
		add_row(hit_item(40, CROSSED, 16'h0000, 16'h1234, 16'h4321));
		add_row(finish_item(16'h0000, 16'h0000), 1, none);
		// Equal distances: the lower sensor wins.
		add_row(hit_item(16 * 700, CROSSED, 16'h0200, 16'h0A00, 16'h0000));
		add_row(hit_item(16 * 5, CROSSED, 16'h0300, 16'h0A00, 16'h0000));
		add_row(hit_item(16 * 9 + 15, CROSSED, 16'h0080, 16'hF600, 16'h0000));
		add_row(finish_item(16'h0000, 16'h0000));
		// Mixed hits on sensors 2 and 512 exercise rounding, including negative hit coordinates.
		add_row(hit_item(33, CROSSED, 16'h0001, 16'hFFFF, 16'h0001));
		add_row(hit_item(34, CROSSED, 16'h0002, 16'h0000, 16'hFFFE));
		add_row(hit_item(35, CROSSED, 16'h0003, 16'h0001, 16'h0003));
		add_row(hit_item(16 * 512, CROSSED, 16'h0007, 16'h8000, 16'h8000));
		add_row(hit_item(16 * 512 + 1, CROSSED, 16'h0009, 16'h7FFF, 16'h7FFF));
		add_row(finish_item(16'h0001, 16'hFFFF));
		// Back-to-back hits on one sensor.
		add_row(hit_item(16 * 256, CROSSED, 16'h8000, 16'h5555, 16'hAAAA));
		add_row(hit_item(16 * 256 + 2, CROSSED, 16'h8000, 16'hAAAA, 16'h5555));
		add_row(hit_item(16 * 256 + 4, CROSSED, 16'hFFFF, 16'h0000, 16'h0000));
		add_row(finish_item(16'h5555, 16'hAAAA));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

		while (sent_items < 400) begin
			if (sent_items > 150 && sent_items < 260) idling_on = 1'b0;
			else idling_on = 1'b1;
			if (sent_items > 300 && sent_items < 320) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			foreach (shared_sensors[k]) shared_sensors[k] = $urandom_range(NUM_SENSORS - 1);
			nhits = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
			for (int h = 0; h < nhits; h++) begin
				sensor = ($urandom_range(2) == 0) ? $urandom_range(NUM_SENSORS - 1)
					: shared_sensors[$urandom_range(3)];
				st = $urandom;
				st[CROSSED_BIT] = ($urandom_range(99) < 85);
				send_item(hit_item(sensor * CHANNELS_PER_SENSOR + $urandom_range(15), st,
					pick_weight(), pick_coord(), pick_coord()));
			end
			send_item(finish_item(pick_coord(), pick_coord()));
		end
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ----- pmt_weighted_centroid_nearest.f -----
rtl/pwcn_pkg.sv
rtl/pwcn_if.sv
rtl/pwcn_div.sv
rtl/pwcn_core.sv
rtl/pmt_weighted_centroid_nearest.sv
rtl/pwcn_checker.sv
sim/pmt_weighted_centroid_nearest_tb.sv
